@@ rtl/srrip_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package srrip_pkg;

  localparam int WAYS = 16;
  localparam int SETS = 64;

  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SET_AW = (SETS > 1) ? $clog2(SETS) : 1;

  // Request and response field widths
  localparam int MODE_W    = 1;
  localparam int SET_W     = 6;
  localparam int WAY_IDX_W = 4;

  localparam int RRPV_W = 2;

  typedef logic [RRPV_W-1:0] rrpv_t;
  typedef rrpv_t [WAYS-1:0] row_t;

  localparam rrpv_t RRPV_NEAR    = 2'd0;
  localparam rrpv_t RRPV_LONG    = 2'd2;
  localparam rrpv_t RRPV_DISTANT = 2'd3;

  localparam row_t ROW_DISTANT = '1;

  localparam logic [MODE_W-1:0] MODE_HIT  = 1'b0;
  localparam logic [MODE_W-1:0] MODE_MISS = 1'b1;

  localparam logic [WAY_W-1:0] WAY_LAST = WAY_W'(WAYS - 1);

  typedef struct packed {
    logic             done;
    rrpv_t            maxv;
    logic [WAY_W-1:0] victim;
  } scan_stat_t;

endpackage

`default_nettype wire

@@ rtl/srrip_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface srrip_req_if;
  logic                               valid;
  logic                               ready;
  logic [srrip_pkg::MODE_W-1:0]       mode;
  logic [srrip_pkg::SET_W-1:0]        set_index;
  logic [srrip_pkg::WAY_IDX_W-1:0]    way_index;

  modport source (output valid, output mode, output set_index, output way_index, input ready);
  modport sink (input valid, input mode, input set_index, input way_index, output ready);
endinterface

interface srrip_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [srrip_pkg::SET_W-1:0]        victim_set;
  logic [srrip_pkg::WAY_IDX_W-1:0]    victim_way;

  modport source (output valid, output victim_set, output victim_way, input ready);
  modport sink (input valid, input victim_set, input victim_way, output ready);
endinterface

`default_nettype wire

@@ rtl/srrip_row_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

module srrip_row_mem (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [srrip_pkg::SET_AW-1:0]  rd_addr,
  output srrip_pkg::row_t               rd_row,
  input  logic                          we,
  input  logic [srrip_pkg::SET_AW-1:0]  wr_addr,
  input  srrip_pkg::row_t               wr_row
);

  srrip_pkg::row_t mem [srrip_pkg::SETS];
  logic [srrip_pkg::SETS-1:0] vld;
  srrip_pkg::row_t rd_data;
  logic rd_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Rows never written read as all counters distant
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_row = rd_vld ? rd_data : srrip_pkg::ROW_DISTANT;

endmodule

`default_nettype wire

@@ rtl/srrip_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none

module srrip_scan (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  srrip_pkg::row_t         row,
  output srrip_pkg::scan_stat_t   stat
);

  logic busy;
  logic [srrip_pkg::WAY_W-1:0] idx;
  logic done;
  srrip_pkg::rrpv_t maxv;
  logic [srrip_pkg::WAY_W-1:0] victim;
  srrip_pkg::rrpv_t lane;
  srrip_pkg::rrpv_t max_next;
  logic [srrip_pkg::WAY_W-1:0] victim_next;

  assign stat = '{done: done, maxv: maxv, victim: victim};

  // One counter per cycle through the shared compare
  assign lane = row[idx];

  always_comb begin
    max_next    = maxv;
    victim_next = victim;
    if (lane > maxv) begin
      max_next    = lane;
      victim_next = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy) begin
        idx <= idx + 1'b1;
        // Stop at the first distant counter or after the last way
        if (max_next == srrip_pkg::RRPV_DISTANT || idx == srrip_pkg::WAY_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      maxv   <= srrip_pkg::RRPV_NEAR;
      victim <= '0;
    end else if (busy) begin
      maxv   <= max_next;
      victim <= victim_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/srrip_set_replacement.sv @@
// SRRIP replacement state for a 64-set, 16-way cache, 2-bit counter per way.
// Request channel (req): mode, set_index, way_index. A hit (mode 0) marks
// the named way as near re-reference and produces no response. A miss
// (mode 1) picks the victim way in the set and returns it on the response
// channel (rsp) as victim_set / victim_way.
// A request is taken only while the block is idle; it then works on it alone.
// Sequence: a hit goes from acceptance to the next acceptance through read,
// load and write. A miss goes through read, load, scan, write and done, and
// raises the response from the done state. The scan steps one way per cycle
// through a single compare unit and stops at the first distant counter or
// after the last way, so it covers 1 to 16 ways.
// Set rows live in a single-port-per-side memory with one valid bit per row.
// Reset: all valid bits clear at once, so every row reads as all counters
// distant right after reset; no clearing pass is needed.
// Stall: the response sits in an output register. If the receiver holds
// ready low, the next request is still accepted and processed; a miss then
// waits in its final state until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module srrip_set_replacement (
  input  logic       clk,
  input  logic       rst,
  srrip_req_if.sink  req,
  srrip_rsp_if.source rsp
);

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_SCAN, S_WRITE, S_DONE} state_t;

  state_t state;

  // Captured request
  logic [srrip_pkg::MODE_W-1:0]    cur_mode;
  logic [srrip_pkg::SET_W-1:0]     cur_set;
  logic [srrip_pkg::WAY_IDX_W-1:0] cur_way;
  logic                            cur_ok;

  srrip_pkg::row_t      row;
  srrip_pkg::row_t      rd_row;
  srrip_pkg::row_t      wr_row;
  srrip_pkg::rrpv_t     age;
  srrip_pkg::scan_stat_t stat;

  logic req_fire;
  logic set_ok;
  logic way_ok;
  logic scan_start;
  logic mem_we;

  logic                            rsp_valid;
  logic [srrip_pkg::SET_W-1:0]     rsp_set;
  logic [srrip_pkg::WAY_IDX_W-1:0] rsp_way;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign set_ok    = int'(req.set_index) < srrip_pkg::SETS;
  assign way_ok    = int'(cur_way) < srrip_pkg::WAYS;

  assign rsp.valid      = rsp_valid;
  assign rsp.victim_set = rsp_set;
  assign rsp.victim_way = rsp_way;

  srrip_row_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (req_fire && set_ok),
    .rd_addr (srrip_pkg::SET_AW'(req.set_index)),
    .rd_row  (rd_row),
    .we      (mem_we),
    .wr_addr (srrip_pkg::SET_AW'(cur_set)),
    .wr_row  (wr_row)
  );

  // Start the victim scan once the row is in its register
  assign scan_start = (state == S_LOAD) && (cur_mode == srrip_pkg::MODE_MISS);

  srrip_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .start (scan_start),
    .row   (row),
    .stat  (stat)
  );

  // Aging brings the set maximum up to distant; the victim is set to long.
  // A hit only clears the named way.
  assign age = srrip_pkg::RRPV_DISTANT - stat.maxv;

  always_comb begin
    for (int w = 0; w < srrip_pkg::WAYS; w++) begin
      if (cur_mode == srrip_pkg::MODE_MISS) begin
        wr_row[w] = (srrip_pkg::WAY_W'(w) == stat.victim) ? srrip_pkg::RRPV_LONG
                                                           : row[w] + age;
      end else begin
        wr_row[w] = (int'(cur_way) == w) ? srrip_pkg::RRPV_NEAR : row[w];
      end
    end
  end

  // Drop hits on ways beyond the set
  assign mem_we = (state == S_WRITE) && ((cur_mode == srrip_pkg::MODE_MISS) || way_ok);

  always_ff @(posedge clk) begin
    if (req_fire) begin
      cur_mode <= req.mode;
      cur_set  <= req.set_index;
      cur_way  <= req.way_index;
      cur_ok   <= set_ok;
    end
    if (state == S_LOAD) begin
      row <= rd_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // The done state reloads the register itself when it is taken
      if (rsp_valid && rsp.ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            if (set_ok) begin
              state <= S_LOAD;
            end else if (req.mode == srrip_pkg::MODE_MISS) begin
              // Set beyond the cache: answer way zero, touch nothing
              state <= S_DONE;
            end
          end
        end
        S_LOAD: begin
          state <= (cur_mode == srrip_pkg::MODE_MISS) ? S_SCAN : S_WRITE;
        end
        S_SCAN: begin
          if (stat.done) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          state <= (cur_mode == srrip_pkg::MODE_MISS) ? S_DONE : S_IDLE;
        end
        S_DONE: begin
          // Hold until the output register is free
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            rsp_set   <= cur_set;
            rsp_way   <= cur_ok ? srrip_pkg::WAY_IDX_W'(stat.victim) : '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_DONE)
    else $error("response raised outside the done state");

  a_scan_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> state == S_SCAN)
    else $error("scan finished while not scanning");

  a_write_after_row: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE |-> $past(state) == S_SCAN || $past(state) == S_LOAD)
    else $error("row write without a loaded row");
`endif

endmodule

`default_nettype wire
